// ===== src/keyed_counting_semaphore_table_macros.svh =====
// Assertion macros shared by the semaphore table checkers.
`ifndef KEYED_COUNTING_SEMAPHORE_TABLE_MACROS_SVH
`define KEYED_COUNTING_SEMAPHORE_TABLE_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during rst.
`define KSEM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled during rst.
`define KSEM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ksem_pkg.sv =====
// Shared sizes, codes and controller/datapath interface types of the semaphore table.
`default_nettype none
package ksem_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int NUM_PROCS  = 8;
  localparam int VALUE_BITS = 16;

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PROC_IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int DT_DEPTH = NUM_PROCS * NUM_SLOTS;
  localparam int DT_AW   = (DT_DEPTH > 1) ? $clog2(DT_DEPTH) : 1;
  localparam int REF_W   = 8;

  localparam logic [REF_W-1:0] REF_MAX = '1;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  typedef enum logic [1:0] {
    K_GET   = 2'd0,
    K_CLOSE = 2'd1,
    K_UP    = 2'd2,
    K_DOWN  = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_BLOCK = 2'd2;

  typedef struct packed {
    logic latch;
    logic scan_step;
    logic sel_slot;
    logic dt_read;
    logic load_ptr;
    logic commit_get;
    logic exec_op;
    logic emit_err;
  } ksem_cmd_t;

  typedef struct packed {
    logic proc_ok;
    logic desc_ok;
    logic is_get;
    logic scan_last;
    logic out_busy;
  } ksem_stat_t;

endpackage
`default_nettype wire

// ===== src/keyed_counting_semaphore_table.sv =====
// A get scans the slot keys, reference counts and descriptor bits one slot per cycle,
// then selects the slot and commits it to the result word.
// Close, up and down read the descriptor memory, then do one slot update.
// One operation is in flight at a time, and the next word is accepted even while a
// result waits.
// Reset is synchronous: all slots, counts and descriptor bindings clear.
`default_nettype none
module keyed_counting_semaphore_table (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic [2:0]         proc_id,
  input  wire logic signed [31:0] key,
  input  wire logic [15:0]        start_value,
  input  wire logic [3:0]         descriptor,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [3:0]              descriptor_out,
  output logic                    wake,
  output logic [3:0]              slot_out
);

  ksem_pkg::ksem_cmd_t  cmd;
  ksem_pkg::ksem_stat_t stat;

  ksem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ksem_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (kind),
    .proc_id        (proc_id),
    .key            (key),
    .start_value    (start_value),
    .descriptor     (descriptor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .descriptor_out (descriptor_out),
    .wake           (wake),
    .slot_out       (slot_out)
  );

endmodule
`default_nettype wire

// ===== src/ksem_ctrl.sv =====
// Controller state machine that sequences each semaphore table operation.
`default_nettype none
module ksem_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ksem_pkg::ksem_stat_t stat,
  output ksem_pkg::ksem_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CHECK   = 8'b0000_0010,
    S_ERR     = 8'b0000_0100,
    S_SCAN    = 8'b0000_1000,
    S_GSEL    = 8'b0001_0000,
    S_GCOMMIT = 8'b0010_0000,
    S_DLOAD   = 8'b0100_0000,
    S_OP      = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.proc_ok) begin
          state_next = S_ERR;
        end else if (stat.is_get) begin
          state_next = S_SCAN;
        end else if (!stat.desc_ok) begin
          state_next = S_ERR;
        end else begin
          cmd.dt_read = 1'b1;
          state_next  = S_DLOAD;
        end
      end
      S_ERR: begin
        if (!stat.out_busy) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_GSEL;
        end
      end
      S_GSEL: begin
        cmd.sel_slot = 1'b1;
        state_next   = S_GCOMMIT;
      end
      S_GCOMMIT: begin
        if (!stat.out_busy) begin
          cmd.commit_get = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_DLOAD: begin
        cmd.load_ptr = 1'b1;
        state_next   = S_OP;
      end
      S_OP: begin
        if (!stat.out_busy) begin
          cmd.exec_op = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ksem_dpath.sv =====
// Datapath with the slot arrays, descriptor table memory and result word register.
`default_nettype none
module ksem_dpath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ksem_pkg::ksem_cmd_t  cmd,
  output ksem_pkg::ksem_stat_t      stat,
  input  wire logic [1:0]           kind,
  input  wire logic [2:0]           proc_id,
  input  wire logic signed [31:0]   key,
  input  wire logic [15:0]          start_value,
  input  wire logic [3:0]           descriptor,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                status,
  output logic [3:0]                descriptor_out,
  output logic                      wake,
  output logic [3:0]                slot_out
);

  logic signed [31:0]                  slot_key      [ksem_pkg::NUM_SLOTS];
  logic [ksem_pkg::VALUE_BITS-1:0]     slot_value    [ksem_pkg::NUM_SLOTS];
  logic [ksem_pkg::REF_W-1:0]          slot_refcount [ksem_pkg::NUM_SLOTS];
  logic [ksem_pkg::NUM_SLOTS-1:0]      dt_valid      [ksem_pkg::NUM_PROCS];
  logic [ksem_pkg::SLOT_W-1:0]         dt_mem        [ksem_pkg::DT_DEPTH];
  logic [ksem_pkg::SLOT_W-1:0]         dt_rdata;

  logic [1:0]                  op_kind;
  logic [2:0]                  op_proc;
  logic signed [31:0]          op_key;
  logic [15:0]                 op_init;
  logic [3:0]                  op_desc;
  logic [ksem_pkg::SLOT_W-1:0] ptr;
  logic [ksem_pkg::SLOT_W-1:0] cand;
  logic [ksem_pkg::SLOT_W-1:0] dsel;
  logic                        found;
  logic                        have;
  logic                        dfree;
  logic                        bound;

  logic [ksem_pkg::PROC_IW-1:0]   row_idx;
  logic [ksem_pkg::SLOT_W-1:0]    desc_idx;
  logic [ksem_pkg::NUM_SLOTS-1:0] cur_row;
  logic [ksem_pkg::DT_AW-1:0]     rd_addr;
  logic [ksem_pkg::DT_AW-1:0]     wr_addr;
  logic                           dt_we;
  logic                           get_ok;
  logic [ksem_pkg::VALUE_BITS-1:0] init_sat;

  assign row_idx  = ksem_pkg::PROC_IW'(op_proc);
  assign desc_idx = ksem_pkg::SLOT_W'(op_desc);
  assign cur_row  = dt_valid[row_idx];
  assign rd_addr  = ksem_pkg::DT_AW'(row_idx) * ksem_pkg::DT_AW'(ksem_pkg::NUM_SLOTS)
                    + ksem_pkg::DT_AW'(desc_idx);
  assign wr_addr  = ksem_pkg::DT_AW'(row_idx) * ksem_pkg::DT_AW'(ksem_pkg::NUM_SLOTS)
                    + ksem_pkg::DT_AW'(dsel);
  assign get_ok   = have && dfree && (slot_refcount[ptr] != ksem_pkg::REF_MAX);
  assign dt_we    = cmd.commit_get && get_ok;
  assign init_sat = (33'(op_init) > 33'(ksem_pkg::VALUE_MAX)) ? ksem_pkg::VALUE_MAX
                    : ksem_pkg::VALUE_BITS'(op_init);

  assign stat.proc_ok   = (32'(op_proc) < ksem_pkg::NUM_PROCS);
  assign stat.desc_ok   = (32'(op_desc) < ksem_pkg::NUM_SLOTS);
  assign stat.is_get    = (op_kind == ksem_pkg::K_GET);
  assign stat.scan_last = (ptr == ksem_pkg::SLOT_W'(ksem_pkg::NUM_SLOTS - 1));
  assign stat.out_busy  = out_valid && !out_ready;

  // The descriptor table stores the bound slot; the valid bits say whether it is bound.
  always_ff @(posedge clk) begin
    if (dt_we) begin
      dt_mem[wr_addr] <= ptr;
    end
    if (cmd.dt_read) begin
      dt_rdata <= dt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_kind <= kind;
      op_proc <= proc_id;
      op_key  <= key;
      op_init <= start_value;
      op_desc <= descriptor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      cand  <= '0;
      dsel  <= '0;
      found <= 1'b0;
      have  <= 1'b0;
      dfree <= 1'b0;
      bound <= 1'b0;
    end else if (cmd.latch) begin
      ptr   <= '0;
      found <= 1'b0;
      have  <= 1'b0;
      dfree <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!found) begin
        if (slot_key[ptr] == op_key) begin
          found <= 1'b1;
          have  <= 1'b1;
          cand  <= ptr;
        end else if (slot_refcount[ptr] == '0) begin
          have <= 1'b1;
          cand <= ptr;
        end
      end
      if (!dfree && !cur_row[ptr]) begin
        dfree <= 1'b1;
        dsel  <= ptr;
      end
      ptr <= ptr + ksem_pkg::SLOT_W'(1);
    end else if (cmd.sel_slot) begin
      ptr <= cand;
    end else if (cmd.load_ptr) begin
      ptr   <= dt_rdata;
      bound <= cur_row[desc_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ksem_pkg::NUM_SLOTS; i++) begin
        slot_key[i]      <= '0;
        slot_value[i]    <= '0;
        slot_refcount[i] <= '0;
      end
      for (int p = 0; p < ksem_pkg::NUM_PROCS; p++) begin
        dt_valid[p] <= '0;
      end
    end else if (dt_we) begin
      if (!found) begin
        slot_key[ptr]   <= op_key;
        slot_value[ptr] <= init_sat;
      end
      slot_refcount[ptr]      <= slot_refcount[ptr] + ksem_pkg::REF_W'(1);
      dt_valid[row_idx][dsel] <= 1'b1;
    end else if (cmd.exec_op && bound) begin
      case (ksem_pkg::kind_t'(op_kind))
        ksem_pkg::K_CLOSE: begin
          if (slot_refcount[ptr] != '0) begin
            slot_refcount[ptr] <= slot_refcount[ptr] - ksem_pkg::REF_W'(1);
          end
          dt_valid[row_idx][desc_idx] <= 1'b0;
        end
        ksem_pkg::K_UP: begin
          if (slot_value[ptr] != ksem_pkg::VALUE_MAX) begin
            slot_value[ptr] <= slot_value[ptr] + ksem_pkg::VALUE_BITS'(1);
          end
        end
        ksem_pkg::K_DOWN: begin
          if (slot_value[ptr] != '0) begin
            slot_value[ptr] <= slot_value[ptr] - ksem_pkg::VALUE_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_err || cmd.commit_get || cmd.exec_op) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err || (cmd.commit_get && !get_ok) || (cmd.exec_op && !bound)) begin
      status         <= ksem_pkg::ST_ERR;
      descriptor_out <= '0;
      wake           <= 1'b0;
      slot_out       <= '0;
    end else if (cmd.commit_get) begin
      status         <= ksem_pkg::ST_OK;
      descriptor_out <= 4'(dsel);
      wake           <= 1'b0;
      slot_out       <= 4'(ptr);
    end else if (cmd.exec_op) begin
      descriptor_out <= '0;
      slot_out       <= 4'(ptr);
      wake           <= (op_kind == ksem_pkg::K_UP);
      if ((op_kind == ksem_pkg::K_DOWN) && (slot_value[ptr] == '0)) begin
        status <= ksem_pkg::ST_BLOCK;
      end else begin
        status <= ksem_pkg::ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/ksem_chk.sv =====
// Port-level checker for the semaphore table and its bind to the top level.
`default_nettype none
`include "keyed_counting_semaphore_table_macros.svh"
module ksem_chk (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         kind,
  input wire logic [2:0]         proc_id,
  input wire logic signed [31:0] key,
  input wire logic [15:0]        start_value,
  input wire logic [3:0]         descriptor,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         status,
  input wire logic [3:0]         descriptor_out,
  input wire logic               wake,
  input wire logic [3:0]         slot_out
);

  `KSEM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot_out), "result word changed while stalled")
  `KSEM_ASSERT_NXT(a_one_inflight, in_valid && in_ready, !in_ready, "second word accepted while one is in flight")
  `KSEM_ASSERT_NOW(a_wake_ok, out_valid && wake, status == ksem_pkg::ST_OK, "wake without ok status")
  `KSEM_ASSERT_NOW(a_err_clean, out_valid && (status == ksem_pkg::ST_ERR), (descriptor_out == 4'd0) && (slot_out == 4'd0) && !wake, "error result carries data")

endmodule

bind keyed_counting_semaphore_table ksem_chk u_ksem_chk (.*);
`default_nettype wire

// ===== bench/tb_keyed_counting_semaphore_table.sv =====
// Self-checking testbench for the keyed counting semaphore table with a built-in predictor.
`default_nettype none
module tb_keyed_counting_semaphore_table;
  import ksem_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_WORDS = 1030;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  proc;
    logic [31:0] key;
    logic [15:0] init;
    logic [3:0]  desc;
  } sem_request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] desc_out;
    logic       wake;
    logic [3:0] slot;
  } sem_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  sem_request_t offer = '0;

  wire logic        in_ready;
  wire logic        out_valid;
  wire logic [1:0]  status;
  wire logic [3:0]  descriptor_out;
  wire logic        wake;
  wire logic [3:0]  slot_out;

  keyed_counting_semaphore_table u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (offer.kind),
    .proc_id        (offer.proc),
    .key            (offer.key),
    .start_value    (offer.init),
    .descriptor     (offer.desc),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .descriptor_out (descriptor_out),
    .wake           (wake),
    .slot_out       (slot_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the semaphore table.
  logic [31:0]           sem_key    [NUM_SLOTS];
  logic [VALUE_BITS-1:0] sem_value  [NUM_SLOTS];
  logic [REF_W-1:0]      sem_refs   [NUM_SLOTS];
  logic [SLOT_W:0]       fd_binding [DT_DEPTH];

  sem_request_t sem_requests[$];
  sem_answer_t  expected_answers[$];
  logic [31:0]  key_pool[10];

  int  mismatches = 0;
  int  words_in = 0;
  int  answers_checked = 0;
  int  gets_bound = 0;
  int  downs_blocked = 0;
  int  error_answers = 0;
  int  stall_cycles = 0;
  logic word_taken = 1'b0;

  function automatic sem_answer_t predict_answer(sem_request_t rq);
    sem_answer_t ans;
    int base;
    int slot;
    int d;
    bit have_slot;
    bit matched;
    bit have_desc;
    logic [SLOT_W:0] entry;
    ans = '0;
    ans.status = ST_ERR;
    slot = 0;
    d = 0;
    have_slot = 0;
    matched = 0;
    have_desc = 0;
    if (int'(rq.proc) >= NUM_PROCS) return ans;
    base = int'(rq.proc) * NUM_SLOTS;
    if (rq.kind == K_GET) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!matched) begin
          if (sem_key[i] == rq.key) begin
            slot = i;
            have_slot = 1;
            matched = 1;
          end else if (sem_refs[i] == 0) begin
            slot = i;
            have_slot = 1;
          end
        end
      end
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
        if (fd_binding[base + i] == 0) begin
          d = i;
          have_desc = 1;
        end
      end
      if (!have_slot || !have_desc || sem_refs[slot] == REF_MAX) return ans;
      if (!matched) begin
        sem_key[slot] = rq.key;
        sem_value[slot] = (32'(rq.init) > 32'(VALUE_MAX)) ? VALUE_MAX : VALUE_BITS'(rq.init);
      end
      sem_refs[slot] = sem_refs[slot] + 1'b1;
      fd_binding[base + d] = (SLOT_W + 1)'(slot + 1);
      ans.status = ST_OK;
      ans.desc_out = 4'(d);
      ans.slot = 4'(slot);
      return ans;
    end
    if (int'(rq.desc) >= NUM_SLOTS) return ans;
    entry = fd_binding[base + int'(rq.desc)];
    if (entry == 0 || int'(entry) > NUM_SLOTS) return ans;
    slot = int'(entry) - 1;
    ans.status = ST_OK;
    ans.slot = 4'(slot);
    case (rq.kind)
      K_CLOSE: begin
        if (sem_refs[slot] != 0) sem_refs[slot] = sem_refs[slot] - 1'b1;
        fd_binding[base + int'(rq.desc)] = '0;
      end
      K_UP: begin
        if (sem_value[slot] != VALUE_MAX) sem_value[slot] = sem_value[slot] + 1'b1;
        ans.wake = 1'b1;
      end
      default: begin
        if (sem_value[slot] == 0) ans.status = ST_BLOCK;
        else sem_value[slot] = sem_value[slot] - 1'b1;
      end
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic queue_request(kind_t k, int p, logic [31:0] ky, logic [15:0] iv, int d);
    sem_request_t rq;
    rq.kind = k;
    rq.proc = 3'(p);
    rq.key = ky;
    rq.init = iv;
    rq.desc = 4'(d);
    sem_requests.push_back(rq);
  endtask

  function automatic logic [15:0] pick_init();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'hFFFE;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_churn_word();
    int sel;
    int p;
    int d;
    logic [31:0] ky;
    kind_t k;
    sel = $urandom_range(0, 99);
    if (sel < 30) k = K_GET;
    else if (sel < 52) k = K_CLOSE;
    else if (sel < 76) k = K_UP;
    else k = K_DOWN;
    p = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, 7);
    d = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(0, 15);
    ky = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, 9)] : $urandom();
    queue_request(k, p, ky, pick_init(), d);
  endtask

  // One process binds every descriptor it has, then another asks for a fresh key,
  // then the first works its semaphores and releases all of them.
  task automatic queue_fill_sequence();
    int p;
    int other;
    p = $urandom_range(0, 7);
    other = (p + $urandom_range(1, 7)) % NUM_PROCS;
    for (int i = 0; i <= NUM_SLOTS; i++)
      queue_request(K_GET, p, $urandom(), pick_init(), $urandom_range(0, 15));
    queue_request(K_GET, other, $urandom(), pick_init(), $urandom_range(0, 15));
    repeat ($urandom_range(4, 10))
      queue_request(($urandom_range(0, 1) != 0) ? K_UP : K_DOWN, p, $urandom(),
                    pick_init(), $urandom_range(0, 15));
    for (int i = 0; i < NUM_SLOTS; i++)
      queue_request(K_CLOSE, p, $urandom(), pick_init(), i);
  endtask

  // Sender: bursts of words separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (sem_requests.size() > 0) begin
      offer <= sem_requests.pop_front();
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: a changing stall pattern, plus one long hold-off that backs up the input.
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_in >= 400) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1;
    end else begin
      case (rx_cycle[8:7])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= 1'($urandom_range(0, 1));
        2'd2: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (rx_cycle[2:0] == 3'd0);
      endcase
    end
  end

  // Monitor: check delivered results first, then predict the word taken at this edge.
  always @(posedge clk) begin
    sem_answer_t want;
    sem_answer_t got;
    if (rst) begin
      word_taken <= 1'b0;
      stall_cycles <= 0;
    end else begin
      word_taken <= in_valid && in_ready;
      stall_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0
                                                                            : stall_cycles + 1;
      if (out_valid && out_ready) begin
        got = '{status, descriptor_out, wake, slot_out};
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected result word, status", int'(status), -1);
        end else begin
          want = expected_answers.pop_front();
          answers_checked <= answers_checked + 1;
          if (got.status != want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
          if (got.desc_out != want.desc_out)
            report_mismatch("descriptor_out", int'(got.desc_out), int'(want.desc_out));
          if (got.wake != want.wake)
            report_mismatch("wake", int'(got.wake), int'(want.wake));
          if (got.slot != want.slot)
            report_mismatch("slot_out", int'(got.slot), int'(want.slot));
        end
      end
      if (in_valid && in_ready) begin
        want = predict_answer(offer);
        expected_answers.push_back(want);
        words_in <= words_in + 1;
        if (want.status == ST_ERR) error_answers <= error_answers + 1;
        if (want.status == ST_BLOCK) downs_blocked <= downs_blocked + 1;
        if (want.status == ST_OK && offer.kind == K_GET) gets_bound <= gets_bound + 1;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Run stopped: no word moved for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sem_key[i] = '0;
      sem_value[i] = '0;
      sem_refs[i] = '0;
    end
    for (int i = 0; i < DT_DEPTH; i++) fd_binding[i] = '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < 10; i++) key_pool[i] = $urandom();

    // Key zero matches the cleared slot zero, so its value starts at zero.
    queue_request(K_GET, 0, 32'h0000_0000, 16'h0005, 9);
    queue_request(K_DOWN, 0, 32'hFFFF_FFFF, 16'hFFFF, 0);
    queue_request(K_UP, 0, 32'h0, 16'h0, 0);
    queue_request(K_DOWN, 0, 32'h0, 16'h0, 0);
    // A fresh key takes the highest free slot; up at the maximum still wakes.
    queue_request(K_GET, 7, 32'h7FFF_FFFF, 16'hFFFF, 15);
    queue_request(K_UP, 7, 32'h0, 16'h0, 0);
    queue_request(K_GET, 7, 32'h8000_0000, 16'h0000, 0);
    queue_request(K_DOWN, 7, 32'h0, 16'h0, 1);
    // An existing key keeps its value when another process opens it.
    queue_request(K_GET, 3, 32'h7FFF_FFFF, 16'h0001, 0);
    queue_request(K_DOWN, 3, 32'h0, 16'h0, 0);
    queue_request(K_CLOSE, 7, 32'h0, 16'h0, 0);
    // Operations on unbound descriptors answer error; then process 0 closes its descriptor.
    queue_request(K_UP, 7, 32'h0, 16'h0, 0);
    queue_request(K_CLOSE, 7, 32'h0, 16'h0, 15);
    queue_request(K_DOWN, 5, 32'h0, 16'h0, 15);
    queue_request(K_CLOSE, 0, 32'h0, 16'h0, 0);
    // A slot with no references is still found by its key.
    queue_request(K_GET, 1, 32'h0000_0000, 16'h0009, 4);
    queue_request(K_DOWN, 1, 32'h0, 16'h0, 0);
    queue_request(K_CLOSE, 3, 32'h0, 16'h0, 0);
    queue_request(K_CLOSE, 7, 32'h0, 16'h0, 1);
    queue_request(K_CLOSE, 1, 32'h0, 16'h0, 0);

    while (sem_requests.size() < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) queue_fill_sequence();
      else repeat (20) queue_churn_word();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (sem_requests.size() != 0 || in_valid || expected_answers.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
    if (expected_answers.size() != 0)
      report_mismatch("results never delivered", 0, expected_answers.size());

    $display("Covered %0d words and %0d checked results: %0d gets bound, %0d downs blocked,",
             words_in, answers_checked, gets_bound, downs_blocked);
    $display("%0d error answers, with descriptor tables and slots filled and drained.",
             error_answers);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
